### hw/rtl/column_melt_screen_wipe_assert.svh
// Assertion macros for the checker file of the column melt wipe.
`ifndef COLUMN_MELT_SCREEN_WIPE_ASSERT_SVH
`define COLUMN_MELT_SCREEN_WIPE_ASSERT_SVH

// Clocked assertion, quiet while reset is applied.
`define CMSW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CMSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/cmsw_pkg.sv
// Shared types, codes, constants and helper function of the column melt wipe.
package cmsw_pkg;

	// Default sizes for the top level parameters
	localparam int DEF_MAX_COLUMNS = 256;
	localparam int DEF_MAX_ROWS    = 1024;

	// Field widths fixed by the stream format
	localparam int ACTION_W        = 2;
	localparam int RANDOM_W        = 8;
	localparam int COLUMN_W        = 8;
	localparam int ROW_W           = 10;
	localparam int PREV_W          = 5;
	localparam int COLUMN_COUNT_W  = 9;
	localparam int SCREEN_HEIGHT_W = 10;
	localparam int S_DATA_W        = 32;
	localparam int S_USER_W        = ACTION_W;
	localparam int M_DATA_W        = 16;
	localparam int M_USER_W        = 1;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 10;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	// Register reset values
	localparam logic [COLUMN_COUNT_W-1:0]  COLUMN_COUNT_RESET  = 9'd160;
	localparam logic [SCREEN_HEIGHT_W-1:0] SCREEN_HEIGHT_RESET = 10'd200;

	// Action codes carried in the input tuser
	localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	// Melt step constants
	localparam int STEP_FAST_LIMIT = 16;
	localparam int STEP_SLOW       = 8;
	localparam int INIT_FLOOR      = -15;

	// Column walk sequencer states
	typedef enum logic [1:0] {
		WS_IDLE,
		WS_WALK,
		WS_DRAIN,
		WS_DONE
	} walk_state_t;

	// Walk sequencer controls toward the datapath
	typedef struct packed {
		logic idle;
		logic rd;
		logic load_done;
	} walk_ctl_t;

	// Starting offset of one column from its random byte
	function automatic logic signed [PREV_W-1:0] init_offset(
		input logic signed [PREV_W-1:0] prev,
		input logic [RANDOM_W-1:0]      rnd,
		input logic                     first
	);
		logic [15:0]       prod;
		logic [6:0]        quot;
		logic [RANDOM_W-1:0] rem;
		logic signed [6:0] sum;
		logic signed [PREV_W-1:0] res;
		// rnd / 3 by reciprocal, exact for eight-bit values
		prod = 16'(rnd) * 16'd171;
		quot = prod[15:9];
		rem  = rnd - RANDOM_W'(quot) * RANDOM_W'(3);
		sum  = 7'(prev) + $signed({5'd0, rem[1:0]}) - 7'sd1;
		if (first) begin
			res = -$signed({1'b0, rnd[3:0]});
		end else if (sum > 7'sd0) begin
			res = '0;
		end else if (sum < 7'(INIT_FLOOR)) begin
			res = PREV_W'(INIT_FLOOR);
		end else begin
			res = sum[PREV_W-1:0];
		end
		return res;
	endfunction

endpackage

### hw/rtl/cmsw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cmsw_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read word, hold it while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/cmsw_step.sv
// One melt step of a single column offset.
module cmsw_step #(
	parameter int OFF_W = 11,
	parameter int HW    = 10
) (
	input  logic signed [OFF_W-1:0] y,
	input  logic [HW-1:0]           h,
	output logic signed [OFF_W-1:0] y_next,
	output logic                    moved
);

	import cmsw_pkg::*;

	localparam int SW = OFF_W + 2;

	logic signed [SW-1:0] y_x;
	logic signed [SW-1:0] h_x;
	logic signed [SW-1:0] dy;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] nxt;

	assign y_x = SW'(y);
	assign h_x = $signed(SW'(h));

	// Count up below zero, fall toward the height below it, hold at or above it
	always_comb begin
		dy    = (y_x < SW'(STEP_FAST_LIMIT)) ? y_x + SW'(1) : SW'(STEP_SLOW);
		sum   = y_x + dy;
		nxt   = y_x;
		moved = 1'b0;
		if (y_x < 0) begin
			nxt   = y_x + SW'(1);
			moved = 1'b1;
		end else if (y_x < h_x) begin
			nxt   = (sum >= h_x) ? h_x : sum;
			moved = 1'b1;
		end
	end

	assign y_next = nxt[OFF_W-1:0];

endmodule

### hw/rtl/cmsw_walk.sv
// Sequencer that walks all columns in use for one tick.
module cmsw_walk #(
	parameter int AW    = 8,
	parameter int CNT_W = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CNT_W-1:0]      ncols,
	input  logic                  out_free,
	output cmsw_pkg::walk_ctl_t   ctl,
	output logic [AW-1:0]         idx
);

	import cmsw_pkg::*;

	walk_state_t state_q;
	walk_state_t state_d;
	logic [AW-1:0] idx_q;
	logic          last;

	assign last = (CNT_W'(idx_q) == ncols - 1'b1);
	assign idx  = idx_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WS_IDLE: begin
				if (start) begin
					state_d = (ncols == '0) ? WS_DONE : WS_WALK;
				end
			end
			WS_WALK: begin
				if (last) begin
					state_d = WS_DRAIN;
				end
			end
			WS_DRAIN: begin
				state_d = WS_DONE;
			end
			WS_DONE: begin
				if (out_free) begin
					state_d = WS_IDLE;
				end
			end
			default: begin
				state_d = WS_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			WS_IDLE:  ctl.idle = 1'b1;
			WS_WALK:  ctl.rd = 1'b1;
			WS_DRAIN: ctl = '0;
			WS_DONE:  ctl.load_done = out_free;
			default:  ctl = '0;
		endcase
	end

	// State and column index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == WS_IDLE) begin
				idx_q <= '0;
			end else if (state_q == WS_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

### hw/rtl/column_melt_screen_wipe.sv
// Column melt wipe: per-column drop offsets in a RAM, init, tick and pixel query.
//
// Input beats arrive on s_axis: tuser holds the action (init, tick or query),
// tdata the random byte, the column and the row. Every accepted beat gives one
// result beat on m_axis: tuser is the source frame select, tdata the source row
// and the done flag. Registers are written through cfg_valid/cfg_index/cfg_data
// and are always ready; write them only while the block is idle.
// Init and query beats are taken one per cycle while m_axis is not stalled; a
// result passes the offset RAM read stage, then the output register, before
// it shows on m_axis. A tick walks the ncols columns in use through the single
// RAM read port and the write port, one column per cycle, ncols being
// column_count limited to MAX_COLUMNS; it keeps s_axis_tready low until its
// done beat enters the output register, later when m_axis is stalled.
// When m_axis_tready is low the output register holds its beat; one more beat
// waits in the RAM read stage, after which s_axis_tready drops.
// After reset no beat is pending, column_count is 160 and screen_height 200.
// The offset RAM is not cleared: query only columns that an init has written.
module column_melt_screen_wipe #(
	parameter int MAX_COLUMNS = cmsw_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = cmsw_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] random_value, [15:8] column, [25:16] row, [31:26] zero
	input  logic [cmsw_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [cmsw_pkg::S_USER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [9:0] source_row, [10] done_res, [15:11] zero
	output logic [cmsw_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// [0] source_select
	output logic [cmsw_pkg::M_USER_W-1:0]  m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cmsw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cmsw_pkg::CFG_DATA_W-1:0] cfg_data
);

	import cmsw_pkg::*;

	localparam int AW    = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int HW    = $clog2(MAX_ROWS);
	localparam int OFF_W = HW + 1;
	localparam int QW    = ((OFF_W > ROW_W) ? OFF_W : ROW_W) + 1;

	// Configuration registers
	logic [COLUMN_COUNT_W-1:0]  column_count_q;
	logic [SCREEN_HEIGHT_W-1:0] screen_height_q;
	logic [CNT_W-1:0]           ncols;
	logic [HW-1:0]              height;

	// Input beat fields
	logic                 s_acc;
	logic [ACTION_W-1:0]  action;
	logic [RANDOM_W-1:0]  random_value;
	logic [COLUMN_W-1:0]  column;
	logic [ROW_W-1:0]     row;
	logic                 col_ok;

	// Init chain
	logic signed [PREV_W-1:0] prev_q;
	logic signed [PREV_W-1:0] init_v;
	logic                     init_wr;

	// RAM ports
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [OFF_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic signed [OFF_W-1:0] ram_rdata;

	// Walk control and write-back stage
	walk_ctl_t               ctl;
	logic [AW-1:0]           walk_idx;
	logic                    wb_valid_s1;
	logic [AW-1:0]           wb_addr_s1;
	logic signed [OFF_W-1:0] step_y;
	logic                    step_moved;
	logic                    moved_q;

	// Read stage of init, query and unknown beats
	logic             valid_s1;
	logic             query_s1;
	logic             colok_s1;
	logic [ROW_W-1:0] row_s1;

	// Query answer
	logic signed [OFF_W-1:0] off;
	logic signed [QW-1:0]    row_x;
	logic signed [QW-1:0]    diff;
	logic                    q_sel;
	logic [ROW_W-1:0]        q_row;

	// Output register
	logic             out_valid_q;
	logic             out_free;
	logic             out_load;
	logic             out_sel_q;
	logic [ROW_W-1:0] out_row_q;
	logic             out_done_q;

	// Unpack the input beat
	assign action       = s_axis_tuser;
	assign random_value = s_axis_tdata[7:0];
	assign column       = s_axis_tdata[15:8];
	assign row          = s_axis_tdata[25:16];
	assign col_ok       = (32'(column) < MAX_COLUMNS);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = ctl.idle && (!valid_s1 || out_free);
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// Limit the registers to what the storage holds
	assign ncols  = (32'(column_count_q) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS)
	                                                    : CNT_W'(column_count_q);
	assign height = (32'(screen_height_q) > MAX_ROWS - 1) ? HW'(MAX_ROWS - 1)
	                                                      : HW'(screen_height_q);

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= COLUMN_COUNT_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_COLUMN_COUNT) begin
				column_count_q <= cfg_data[COLUMN_COUNT_W-1:0];
			end else if (cfg_index == REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data;
			end
		end
	end

	// Init offset chain
	assign init_v  = init_offset(prev_q, random_value, column == '0);
	assign init_wr = s_acc && (action == ACT_INIT) && col_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (init_wr) begin
			prev_q <= init_v;
		end
	end

	// Offset RAM: init and tick write-back share the write port
	assign ram_we    = init_wr || (wb_valid_s1 && step_moved);
	assign ram_waddr = wb_valid_s1 ? wb_addr_s1 : AW'(column);
	assign ram_wdata = wb_valid_s1 ? step_y : OFF_W'(init_v);
	assign ram_re    = (s_acc && (action == ACT_QUERY)) || ctl.rd;
	assign ram_raddr = ctl.rd ? walk_idx : AW'(column);

	cmsw_ram #(
		.WIDTH (OFF_W),
		.DEPTH (MAX_COLUMNS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Tick walk sequencer
	cmsw_walk #(
		.AW    (AW),
		.CNT_W (CNT_W)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_acc && (action == ACT_TICK)),
		.ncols    (ncols),
		.out_free (out_free),
		.ctl      (ctl),
		.idx      (walk_idx)
	);

	// Melt step on the word read back
	cmsw_step #(
		.OFF_W (OFF_W),
		.HW    (HW)
	) u_step (
		.y      (ram_rdata),
		.h      (height),
		.y_next (step_y),
		.moved  (step_moved)
	);

	// Track the write-back address and whether any column moved
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_s1 <= 1'b0;
			moved_q     <= 1'b0;
		end else begin
			wb_valid_s1 <= ctl.rd;
			if (s_acc && (action == ACT_TICK)) begin
				moved_q <= 1'b0;
			end else if (wb_valid_s1 && step_moved) begin
				moved_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= walk_idx;
	end

	// Read stage of init, query and unknown beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc && (action != ACT_TICK)) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			query_s1 <= (action == ACT_QUERY);
			colok_s1 <= col_ok;
			row_s1   <= row;
		end
	end

	// Answer a pixel query from the offset read back
	assign off   = colok_s1 ? ram_rdata : '0;
	assign row_x = $signed(QW'(row_s1));
	assign diff  = row_x - QW'(off);
	assign q_sel = (off > 0) && (diff < 0);
	assign q_row = ((off > 0) && !q_sel) ? diff[ROW_W-1:0] : row_s1;

	// Output register
	assign out_load = (valid_s1 && out_free) || ctl.load_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ctl.load_done) begin
				out_sel_q  <= 1'b0;
				out_row_q  <= '0;
				out_done_q <= !moved_q;
			end else begin
				out_sel_q  <= query_s1 && q_sel;
				out_row_q  <= query_s1 ? q_row : '0;
				out_done_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_done_q, out_row_q};
	assign m_axis_tuser  = out_sel_q;

endmodule

### hw/rtl/cmsw_checker.sv
// Port checker for the column melt wipe, bound to the top level.
`include "column_melt_screen_wipe_assert.svh"

module cmsw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [cmsw_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [cmsw_pkg::M_USER_W-1:0] m_axis_tuser
);

	// A stalled result beat holds
	`CMSW_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

	// Padding bits of the result stay zero
	`CMSW_ASSERT(a_out_pad, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata[15:11] == 5'd0), "result padding not zero")

	// A beat with the done flag set clears the frame select and the source row
	`CMSW_ASSERT(a_done_excl, clk, arst_n, m_axis_tvalid && m_axis_tdata[10] |-> (m_axis_tuser[0] == 1'b0) && (m_axis_tdata[9:0] == 10'd0), "done beat carries query fields")

	// No result beat in the cycle after reset is seen
	`CMSW_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_axis_tvalid, "result beat right after reset")

endmodule

bind column_melt_screen_wipe cmsw_checker u_cmsw_checker (.*);
